// ----- rtl/fcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared types and constants of the FLI frame chunk decoder.
// ----------------------------------------------------------------------------
package fcd_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_HEIGHT  = 1024;
  localparam int PALETTE_ENTRIES = 256;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [2:0] KIND_FILL    = 3'd0;
  localparam logic [2:0] KIND_PATTERN = 3'd1;
  localparam logic [2:0] KIND_PALETTE = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_DROPPED = 3'd4;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  localparam logic [4:0] CK_PAL256 = 5'd4;
  localparam logic [4:0] CK_DELTA  = 5'd7;
  localparam logic [4:0] CK_PAL64  = 5'd11;
  localparam logic [4:0] CK_LINE   = 5'd12;
  localparam logic [4:0] CK_BLACK  = 5'd13;
  localparam logic [4:0] CK_BRUN   = 5'd15;
  localparam logic [4:0] CK_COPY   = 5'd16;
  localparam logic [4:0] CK_THUMB  = 5'd18;

  typedef struct packed {
    logic [2:0]  kind;
    logic [19:0] address;
    logic [20:0] count;
    logic [7:0]  index_a;
    logic [7:0]  index_b;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        refresh_all;
    logic        last;
  } fcd_res_t;

endpackage

// ----- rtl/fcd_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_parser
// Front end: parses frame and chunk headers and chunk bodies one byte per
// cycle while in_take is high, with up to two result transactions per byte.
// ----------------------------------------------------------------------------
module fcd_parser
  import fcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_take,
  input  logic [7:0]  in_byte,
  input  logic [10:0] used_w,
  input  logic [10:0] used_h,
  input  logic [21:0] area,
  output fcd_res_t    res0,
  output fcd_res_t    res1,
  output logic [1:0]  res_vld
);

  typedef enum logic [25:0] {
    P_FSIZE     = 26'd1 << 0,
    P_MAGIC     = 26'd1 << 1,
    P_NCHUNK    = 26'd1 << 2,
    P_PAD       = 26'd1 << 3,
    P_CSIZE     = 26'd1 << 4,
    P_CTYPE     = 26'd1 << 5,
    P_SKIP      = 26'd1 << 6,
    P_PAL_NPK   = 26'd1 << 7,
    P_PAL_SKIP  = 26'd1 << 8,
    P_PAL_CNT   = 26'd1 << 9,
    P_PAL_RGB   = 26'd1 << 10,
    P_DL_NLINES = 26'd1 << 11,
    P_DL_WORD   = 26'd1 << 12,
    P_DL_RUN    = 26'd1 << 13,
    P_DL_PAT1   = 26'd1 << 14,
    P_DL_PAT2   = 26'd1 << 15,
    P_LC_START  = 26'd1 << 16,
    P_LC_NLINES = 26'd1 << 17,
    P_LC_NPK    = 26'd1 << 18,
    P_LC_RUN    = 26'd1 << 19,
    P_BR_NPK    = 26'd1 << 20,
    P_BR_RUN    = 26'd1 << 21,
    P_PSKIP     = 26'd1 << 22,
    P_LIT       = 26'd1 << 23,
    P_FILL      = 26'd1 << 24,
    P_CP_BYTE   = 26'd1 << 25
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] fs_r, fs_nxt, fbl_r, fbl_nxt, cbl_r, cbl_nxt;
  logic [2:0]  bif_r, bif_nxt;
  logic [15:0] chl_r, chl_nxt, ll_r, ll_nxt, pk_r, pk_nxt, cb_r, cb_nxt;
  logic [4:0]  ck_r, ck_nxt;
  logic [29:0] lb_r, lb_nxt, pp_r, pp_nxt;
  logic [8:0]  rl_r, rl_nxt;
  logic [7:0]  pal_r, pal_nxt, fi_r, fi_nxt;
  logic        rf_r, rf_nxt;

  logic [31:0] v;
  logic        done2, done4, is_body, do_pd, do_le, do_ec, do_fd, pv;
  logic [15:0] mul_op;
  logic [26:0] prod;
  logic [7:0]  mag;
  logic [1:0]  sh;
  fcd_res_t    pres, fres;

  function automatic logic [29:0] adv(input logic [29:0] a, input logic [26:0] d);
    logic [30:0] s;
    s = {1'b0, a} + {4'b0, d};
    return s[30] ? 30'h3FFFFFFF : s[29:0];
  endfunction

  function automatic fcd_res_t mk_pix(input logic [2:0] kind, input logic [29:0] addr,
                                      input logic [21:0] npix, input logic [20:0] cnt,
                                      input logic [7:0] ia, input logic [7:0] ib,
                                      input logic [21:0] ar);
    fcd_res_t r;
    r = '0;
    r.kind    = (({1'b0, addr} + {9'b0, npix}) > {9'b0, ar}) ? KIND_DROPPED : kind;
    r.address = addr[19:0];
    r.count   = cnt;
    r.index_a = ia;
    r.index_b = ib;
    return r;
  endfunction

  assign v      = fs_r | ({24'b0, in_byte} << {bif_r[1:0], 3'b000});
  assign done2  = bif_r >= 3'd1;
  assign done4  = bif_r >= 3'd3;
  assign mul_op = (phase_r == P_LC_START) ? v[15:0] : 16'(17'h10000 - {1'b0, v[15:0]});
  assign prod   = mul_op * used_w;
  assign mag    = 8'(-in_byte);

  always_comb begin
    phase_nxt = phase_r; fs_nxt = fs_r; bif_nxt = bif_r; fbl_nxt = fbl_r;
    chl_nxt = chl_r; cbl_nxt = cbl_r; ck_nxt = ck_r; lb_nxt = lb_r; pp_nxt = pp_r;
    ll_nxt = ll_r; pk_nxt = pk_r; rl_nxt = rl_r; pal_nxt = pal_r; cb_nxt = cb_r;
    fi_nxt = fi_r; rf_nxt = rf_r;
    is_body = 1'b1; do_pd = 1'b0; do_le = 1'b0; do_ec = 1'b0; do_fd = 1'b0;
    pv = 1'b0; pres = '0; fres = '0;
    sh = (ck_r == CK_PAL64) ? 2'd2 : 2'd0;
    if (in_take) begin
      unique case (phase_r)
        P_FSIZE, P_MAGIC, P_NCHUNK, P_CSIZE, P_CTYPE: begin
          is_body = 1'b0;
          fs_nxt  = v;
          bif_nxt = bif_r + 3'd1;
          if ((phase_r == P_FSIZE || phase_r == P_CSIZE) ? done4 : done2) begin
            fs_nxt  = '0;
            bif_nxt = '0;
            if (phase_r == P_FSIZE) begin
              fbl_nxt   = (v >= 32'd16) ? v - 32'd16 : '0;
              phase_nxt = P_MAGIC;
            end else if (phase_r == P_MAGIC) begin
              phase_nxt = P_NCHUNK;
            end else if (phase_r == P_NCHUNK) begin
              chl_nxt   = v[15:0];
              phase_nxt = P_PAD;
            end else if (phase_r == P_CSIZE) begin
              fbl_nxt   = (v >= fbl_r) ? '0 : fbl_r - v;
              if (chl_r != 16'd0) chl_nxt = chl_r - 16'd1;
              cbl_nxt   = (v > 32'd6) ? v - 32'd6 : '0;
              phase_nxt = P_CTYPE;
            end else begin
              ck_nxt    = '0;
              phase_nxt = P_SKIP;
              if (v[15:5] == 11'd0) begin
                unique case (v[4:0])
                  CK_PAL256, CK_PAL64: begin
                    ck_nxt = v[4:0]; rf_nxt = 1'b1; phase_nxt = P_PAL_NPK;
                  end
                  CK_DELTA: begin
                    ck_nxt = v[4:0]; phase_nxt = P_DL_NLINES;
                  end
                  CK_LINE: begin
                    ck_nxt = v[4:0]; phase_nxt = P_LC_START;
                  end
                  CK_BLACK: begin
                    ck_nxt = v[4:0]; rf_nxt = 1'b1; pv = 1'b1;
                    pres = mk_pix(KIND_FILL, '0, area, area[20:0], '0, '0, area);
                  end
                  CK_BRUN: begin
                    ck_nxt = v[4:0]; lb_nxt = '0; ll_nxt = {5'b0, used_h};
                    if (used_h != 11'd0) phase_nxt = P_BR_NPK;
                  end
                  CK_COPY: begin
                    ck_nxt = v[4:0];
                    if (cbl_r <= {10'b0, area}) begin
                      rf_nxt = 1'b1; pp_nxt = '0; phase_nxt = P_CP_BYTE;
                    end
                  end
                  CK_THUMB: ck_nxt = v[4:0];
                  default: ;
                endcase
              end
              if (cbl_r == 32'd0) do_ec = 1'b1;
            end
          end
        end
        P_PAD: begin
          is_body = 1'b0;
          bif_nxt = bif_r + 3'd1;
          if (bif_r == 3'd7) begin
            bif_nxt = '0;
            if (chl_r == 16'd0 || fbl_r == 32'd0) do_fd = 1'b1;
            else phase_nxt = P_CSIZE;
          end
        end
        P_SKIP: ;
        P_PAL_NPK, P_DL_NLINES, P_DL_WORD, P_LC_START, P_LC_NLINES: begin
          fs_nxt  = v;
          bif_nxt = bif_r + 3'd1;
          if (done2) begin
            fs_nxt  = '0;
            bif_nxt = '0;
            if (phase_r == P_PAL_NPK) begin
              pk_nxt = v[15:0]; pal_nxt = '0;
              phase_nxt = (v[15:0] != 16'd0) ? P_PAL_SKIP : P_SKIP;
            end else if (phase_r == P_DL_NLINES) begin
              ll_nxt = v[15:0]; lb_nxt = '0;
              phase_nxt = (v[15:0] != 16'd0) ? P_DL_WORD : P_SKIP;
            end else if (phase_r == P_LC_START) begin
              lb_nxt = {3'b0, prod}; phase_nxt = P_LC_NLINES;
            end else if (phase_r == P_LC_NLINES) begin
              ll_nxt = v[15:0];
              phase_nxt = (v[15:0] != 16'd0) ? P_LC_NPK : P_SKIP;
            end else if (v[15:14] == 2'b11) begin
              lb_nxt = adv(lb_r, prod);
            end else if (v[15:14] == 2'b10) begin
              pv   = 1'b1;
              pres = mk_pix(KIND_FILL,
                            (used_w != 11'd0) ? adv(lb_r, 27'(used_w - 11'd1)) : lb_r,
                            22'd1, 21'd1, v[7:0], '0, area);
            end else if (v[15:0] == 16'd0) begin
              do_le = 1'b1;
            end else begin
              pk_nxt = v[15:0]; pp_nxt = lb_r; phase_nxt = P_PSKIP;
            end
          end
        end
        P_PAL_SKIP: begin
          pal_nxt = pal_r + in_byte; phase_nxt = P_PAL_CNT;
        end
        P_PAL_CNT: begin
          rl_nxt = (in_byte != 8'd0) ? {1'b0, in_byte} : 9'd256;
          bif_nxt = '0; phase_nxt = P_PAL_RGB;
        end
        P_PAL_RGB: begin
          if (bif_r == 3'd0) begin
            cb_nxt = {8'b0, in_byte}; bif_nxt = 3'd1;
          end else if (bif_r == 3'd1) begin
            cb_nxt = {in_byte, cb_r[7:0]}; bif_nxt = 3'd2;
          end else begin
            bif_nxt = '0;
            pv = 1'b1;
            pres.kind    = KIND_PALETTE;
            pres.address = {12'b0, pal_r};
            pres.red     = cb_r[7:0] << sh;
            pres.green   = cb_r[15:8] << sh;
            pres.blue    = in_byte << sh;
            pal_nxt = pal_r + 8'd1;
            rl_nxt  = rl_r - 9'd1;
            if (rl_nxt == 9'd0) begin
              if (pk_r != 16'd0) pk_nxt = pk_r - 16'd1;
              phase_nxt = (pk_nxt != 16'd0) ? P_PAL_SKIP : P_SKIP;
            end
          end
        end
        P_DL_RUN: begin
          if (in_byte[7]) begin
            rl_nxt = {1'b0, mag}; phase_nxt = P_DL_PAT1;
          end else if (in_byte == 8'd0) begin
            do_pd = 1'b1;
          end else begin
            rl_nxt = {in_byte, 1'b0}; phase_nxt = P_LIT;
          end
        end
        P_DL_PAT1: begin
          fi_nxt = in_byte; phase_nxt = P_DL_PAT2;
        end
        P_DL_PAT2: begin
          pv = 1'b1;
          pres = mk_pix(KIND_PATTERN, pp_r, {12'b0, rl_r, 1'b0}, {12'b0, rl_r},
                        fi_r, in_byte, area);
          pp_nxt = adv(pp_r, {17'b0, rl_r, 1'b0});
          do_pd = 1'b1;
        end
        P_LC_NPK, P_BR_NPK: begin
          pk_nxt = {8'b0, in_byte}; pp_nxt = lb_r;
          if (in_byte == 8'd0) do_le = 1'b1;
          else phase_nxt = (phase_r == P_LC_NPK) ? P_PSKIP : P_BR_RUN;
        end
        P_LC_RUN: begin
          if (!in_byte[7] && in_byte != 8'd0) begin
            rl_nxt = {1'b0, in_byte}; phase_nxt = P_LIT;
          end else begin
            rl_nxt = {1'b0, mag}; phase_nxt = P_FILL;
          end
        end
        P_BR_RUN: begin
          if (in_byte[7]) begin
            rl_nxt = {1'b0, mag}; phase_nxt = P_LIT;
          end else if (in_byte == 8'd0) begin
            do_pd = 1'b1;
          end else begin
            rl_nxt = {1'b0, in_byte}; phase_nxt = P_FILL;
          end
        end
        P_PSKIP: begin
          pp_nxt = adv(pp_r, {19'b0, in_byte});
          phase_nxt = (ck_r == CK_DELTA) ? P_DL_RUN : P_LC_RUN;
        end
        P_LIT, P_CP_BYTE: begin
          pv = 1'b1;
          pres = mk_pix(KIND_FILL, pp_r, 22'd1, 21'd1, in_byte, '0, area);
          pp_nxt = adv(pp_r, 27'd1);
          if (phase_r == P_LIT) begin
            if (rl_r != 9'd0) rl_nxt = rl_r - 9'd1;
            if (rl_nxt == 9'd0) do_pd = 1'b1;
          end
        end
        P_FILL: begin
          if (rl_r != 9'd0) begin
            pv = 1'b1;
            pres = mk_pix(KIND_FILL, pp_r, {13'b0, rl_r}, {12'b0, rl_r}, in_byte, '0, area);
          end
          pp_nxt = adv(pp_r, {18'b0, rl_r});
          do_pd = 1'b1;
        end
        default: ;
      endcase
      if (do_pd && ck_r != CK_COPY) begin
        if (pk_r != 16'd0) pk_nxt = pk_r - 16'd1;
        if (pk_nxt == 16'd0) do_le = 1'b1;
        else phase_nxt = (ck_r == CK_BRUN) ? P_BR_RUN : P_PSKIP;
      end
      if (do_le) begin
        lb_nxt = adv(lb_r, {16'b0, used_w});
        if (ll_r != 16'd0) ll_nxt = ll_r - 16'd1;
        if (ll_nxt == 16'd0) phase_nxt = P_SKIP;
        else if (ck_r == CK_DELTA) phase_nxt = P_DL_WORD;
        else if (ck_r == CK_LINE) phase_nxt = P_LC_NPK;
        else phase_nxt = P_BR_NPK;
      end
      if (is_body) begin
        if (cbl_r != 32'd0) cbl_nxt = cbl_r - 32'd1;
        if (cbl_nxt == 32'd0) do_ec = 1'b1;
      end
      if (do_ec) begin
        fs_nxt = '0; bif_nxt = '0;
        if (chl_nxt == 16'd0 || fbl_nxt == 32'd0) do_fd = 1'b1;
        else phase_nxt = P_CSIZE;
      end
      if (do_fd) begin
        fres.kind = KIND_DONE;
        fres.refresh_all = rf_nxt;
        rf_nxt = 1'b0;
        phase_nxt = P_FSIZE;
      end
    end
  end

  always_comb begin
    res0 = pv ? pres : fres;
    res1 = fres;
    res0.last = !(pv && do_fd);
    res1.last = 1'b1;
    res_vld = {pv && do_fd, pv || do_fd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_FSIZE; fs_r <= '0; bif_r <= '0; fbl_r <= '0; chl_r <= '0;
      cbl_r <= '0; ck_r <= '0; lb_r <= '0; pp_r <= '0; ll_r <= '0; pk_r <= '0;
      rl_r <= '0; pal_r <= '0; cb_r <= '0; fi_r <= '0; rf_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; fs_r <= fs_nxt; bif_r <= bif_nxt; fbl_r <= fbl_nxt;
      chl_r <= chl_nxt; cbl_r <= cbl_nxt; ck_r <= ck_nxt; lb_r <= lb_nxt;
      pp_r <= pp_nxt; ll_r <= ll_nxt; pk_r <= pk_nxt; rl_r <= rl_nxt;
      pal_r <= pal_nxt; cb_r <= cb_nxt; fi_r <= fi_nxt; rf_r <= rf_nxt;
    end
  end

endmodule

// ----- rtl/fcd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_queue
// Result queue: takes up to two transactions per cycle, hands out one.
// ----------------------------------------------------------------------------
module fcd_queue
  import fcd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  fcd_res_t   wr0,
  input  fcd_res_t   wr1,
  input  logic [1:0] wr_vld,
  output logic       room_low,
  input  logic       rd_pop,
  output logic       rd_empty,
  output fcd_res_t   rd_data
);

  localparam int AW = $clog2(DEPTH);

  fcd_res_t          mem [DEPTH];
  logic [AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic              pop;

  assign rd_empty = (cnt_r == '0);
  assign room_low = (cnt_r > (AW+1)'(DEPTH - 2));
  assign pop      = rd_pop && !rd_empty;
  assign rd_data  = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r + AW'(wr_vld[0]) + AW'(wr_vld[1]);
    rp_nxt  = rp_r + AW'(pop);
    cnt_nxt = cnt_r + (AW+1)'(wr_vld[0]) + (AW+1)'(wr_vld[1]) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (wr_vld[0]) mem[wp_r] <= wr0;
    if (wr_vld[1]) mem[AW'(wp_r + AW'(1))] <= wr1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/fli_frame_chunk_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fli_frame_chunk_decoder
// FLI frame and chunk decoder producing palette writes and pixel commands.
// ----------------------------------------------------------------------------
// The decoder takes one stream byte per cycle while in_full is low, with no
// gaps of its own: the parser updates its state for each byte and pushes
// zero, one or two result transactions into a four-entry queue, from which
// results leave one per cycle as out_pop takes them. full rises while the
// queue has room for fewer than two results, so a stalled result side holds
// the byte stream back. Width and height writes are stored clamped to the
// maximum frame size, and the frame area is formed at the write.
module fli_frame_chunk_decoder
  import fcd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_kind,
  output logic [19:0] out_address,
  output logic [20:0] out_count,
  output logic [7:0]  out_index_a,
  output logic [7:0]  out_index_b,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_refresh_all,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);

  logic [10:0] uw_r, uh_r, cfg_w, cfg_h;
  logic [21:0] area_r;
  fcd_res_t    res0, res1, head;
  logic [1:0]  res_vld;

  assign cfg_w = ({21'b0, cfg_wdata} > 32'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : cfg_wdata;
  assign cfg_h = ({21'b0, cfg_wdata} > 32'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uw_r   <= 11'd320;
      uh_r   <= 11'd200;
      area_r <= 22'd64000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH: begin
          uw_r   <= cfg_w;
          area_r <= cfg_w * uh_r;
        end
        CFG_HEIGHT: begin
          uh_r   <= cfg_h;
          area_r <= uw_r * cfg_h;
        end
        default: ;
      endcase
    end
  end

  fcd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_push && !in_full),
    .in_byte (in_data_byte),
    .used_w  (uw_r),
    .used_h  (uh_r),
    .area    (area_r),
    .res0    (res0),
    .res1    (res1),
    .res_vld (res_vld)
  );

  fcd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr0      (res0),
    .wr1      (res1),
    .wr_vld   (res_vld),
    .room_low (in_full),
    .rd_pop   (out_pop),
    .rd_empty (out_empty),
    .rd_data  (head)
  );

  assign out_kind        = head.kind;
  assign out_address     = head.address;
  assign out_count       = head.count;
  assign out_index_a     = head.index_a;
  assign out_index_b     = head.index_b;
  assign out_red         = head.red;
  assign out_green       = head.green;
  assign out_blue        = head.blue;
  assign out_refresh_all = head.refresh_all;
  assign out_last        = head.last;

endmodule
